FILE: design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

FILE: design/nch_pkg.sv
package nch_pkg;
  localparam int MAX_CENTRES   = 1024;
  localparam int MAX_DESC_LEN  = 128;
  localparam int ELEM_W        = 16;
  localparam int COUNT_W       = 32;
  localparam int CI_W          = 10;
  localparam int EI_W          = 7;
  localparam int DIST_W        = 40;
  localparam int CB_AW         = CI_W + EI_W;
  localparam int NC_W          = 11;
  localparam int LEN_W         = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_DESC = 2'd1, OP_READ = 2'd2, OP_CLEAR = 2'd3
  } op_t;

  localparam logic CFG_CENTRES = 1'b0;
  localparam logic CFG_LEN     = 1'b1;

  typedef struct packed {
    logic [1:0]      op;
    logic [CI_W-1:0] ci;
  } cmd_t;
endpackage

FILE: design/nch_ram.sv
module nch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/nch_front.sv
module nch_front import nch_pkg::*; (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic [CI_W-1:0]          in_centre_index,
  input  logic [EI_W-1:0]          in_element_index,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic [LEN_W-1:0]         len,
  output logic                     cb_we,
  output logic [CB_AW-1:0]         cb_waddr,
  output logic [ELEM_W-1:0]        wdata,
  output logic                     db_we,
  output logic                     q_push,
  output cmd_t                     q_cmd,
  input  logic                     q_full
);
  logic acc;
  logic [LEN_W-1:0] lenl;
  assign lenl = (len == '0) ? LEN_W'(1) :
                (len > LEN_W'(MAX_DESC_LEN)) ? LEN_W'(MAX_DESC_LEN) : len;
  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign cb_we = acc && in_op == OP_LOAD;
  assign cb_waddr = {in_centre_index, in_element_index};
  assign wdata = in_element_value;
  assign db_we = acc && in_op == OP_DESC;
  always_comb begin
    q_push = 1'b0;
    unique case (in_op) inside
      OP_DESC:           q_push = acc && ({1'b0, in_element_index} == lenl - LEN_W'(1));
      OP_READ, OP_CLEAR: q_push = acc;
      default:           q_push = 1'b0;
    endcase
  end
  assign q_cmd = '{op: in_op, ci: in_centre_index};
endmodule

FILE: design/nch_queue.sv
module nch_queue import nch_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t dout
);
  cmd_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: design/nch_back.sv
module nch_back import nch_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  input  logic [NC_W-1:0]    ncent,
  input  logic [LEN_W-1:0]   len,
  output logic [CB_AW-1:0]   cb_raddr,
  input  logic [ELEM_W-1:0]  cb_rdata,
  output logic [EI_W-1:0]    db_raddr,
  input  logic [ELEM_W-1:0]  db_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic [CI_W-1:0]    out_nearest_centre,
  output logic [DIST_W-1:0]  out_min_distance,
  output logic [COUNT_W-1:0] out_bin_count,
  output logic               busy
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RUN = 6'b000010, S_HRD = 6'b000100,
    S_HUPD = 6'b001000, S_OUT = 6'b010000, S_CLR = 6'b100000
  } st_t;
  st_t st_r, st_nxt;
  logic [CI_W-1:0] c_r, best_r, ci_r;
  logic [EI_W-1:0] e_r;
  logic v1_r, v2_r, v3_r, last1_r, last2_r, last3_r, first1_r, first2_r, first3_r;
  logic [CI_W-1:0] c1_r, c2_r, c3_r;
  logic signed [ELEM_W:0] diff_r;
  logic [2*ELEM_W+1:0] sq_r;
  logic [DIST_W-1:0] acc_r, best_d_r, sum, dist_c;
  logic acc_sat_r;
  logic kind_r;
  logic [NC_W-1:0] ncl;
  logic [LEN_W-1:0] lenl;
  logic [CI_W-1:0] clr_r;
  logic addr_last, res_last;
  logic h_we;
  logic [CI_W-1:0] h_addr;
  logic [COUNT_W-1:0] h_wd, h_rd;

  assign ncl = (ncent == '0) ? NC_W'(1) :
               (ncent > NC_W'(MAX_CENTRES)) ? NC_W'(MAX_CENTRES) : ncent;
  assign lenl = (len == '0) ? LEN_W'(1) :
                (len > LEN_W'(MAX_DESC_LEN)) ? LEN_W'(MAX_DESC_LEN) : len;
  assign cb_raddr = {c_r, e_r};
  assign db_raddr = e_r;
  assign busy = st_r != S_IDLE;
  assign addr_last = c_r == CI_W'(ncl - NC_W'(1)) && e_r == EI_W'(lenl - LEN_W'(1));
  assign res_last = v3_r && last3_r && c3_r == CI_W'(ncl - NC_W'(1));

  nch_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_CENTRES)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_addr), .wdata(h_wd), .raddr(h_addr), .rdata(h_rd)
  );

  // histogram cleared by a full pass after reset and on a clear request
  assign h_addr = (st_r == S_CLR) ? clr_r : kind_r ? ci_r : best_r;
  assign h_we = st_r == S_CLR || (st_r == S_HUPD && !kind_r);
  assign h_wd = (st_r == S_CLR) ? '0 : (h_rd == COUNT_MAX) ? h_rd : h_rd + COUNT_W'(1);

  always_comb begin
    logic [DIST_W:0] s;
    s = {1'b0, acc_r} + {{(DIST_W-2*ELEM_W-1){1'b0}}, sq_r};
    sum = (acc_sat_r || s[DIST_W] || s[DIST_W-1:0] == DIST_MAX) ? DIST_MAX : s[DIST_W-1:0];
  end

  assign dist_c = first3_r ? {{(DIST_W-2*ELEM_W-2){1'b0}}, sq_r} : sum;

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        unique case (q_cmd.op)
          OP_DESC:  st_nxt = S_RUN;
          OP_READ:  st_nxt = S_HRD;
          default:  st_nxt = S_CLR;
        endcase
      end
      S_RUN:  if (res_last) st_nxt = S_HRD;
      S_HRD:  st_nxt = S_HUPD;
      S_HUPD: st_nxt = S_OUT;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      S_CLR:  if (clr_r == CI_W'(MAX_CENTRES - 1)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + CI_W'(1);
      v1_r <= st_r == S_RUN;
      v2_r <= v1_r && st_r == S_RUN;
      v3_r <= v2_r && st_r == S_RUN;
    end
    if (st_r == S_IDLE && !q_empty) begin
      kind_r <= q_cmd.op != OP_DESC;
      ci_r <= q_cmd.ci;
      c_r <= '0;
      e_r <= '0;
      best_r <= '0;
      best_d_r <= DIST_MAX;
      first1_r <= 1'b0;
    end
    if (st_r == S_RUN) begin
      if (!addr_last) begin
        if (e_r == EI_W'(lenl - LEN_W'(1))) begin
          e_r <= '0;
          c_r <= c_r + CI_W'(1);
        end else e_r <= e_r + EI_W'(1);
      end
      last1_r <= e_r == EI_W'(lenl - LEN_W'(1));
      first1_r <= e_r == '0;
      c1_r <= c_r;
      diff_r <= $signed({cb_rdata[ELEM_W-1], cb_rdata}) - $signed({db_rdata[ELEM_W-1], db_rdata});
      last2_r <= last1_r;
      first2_r <= first1_r;
      c2_r <= c1_r;
      last3_r <= last2_r;
      first3_r <= first2_r;
      c3_r <= c2_r;
      sq_r <= (2*ELEM_W+2)'(diff_r * diff_r);
      if (v3_r) begin
        if (first3_r) begin
          acc_r <= {{(DIST_W-2*ELEM_W-2){1'b0}}, sq_r};
          acc_sat_r <= 1'b0;
        end else begin
          acc_r <= sum;
          acc_sat_r <= sum == DIST_MAX;
        end
      end
      if (v3_r && last3_r && (c3_r == '0 || dist_c < best_d_r)) begin
        best_d_r <= dist_c;
        best_r <= c3_r;
      end
    end
    if (st_r == S_HUPD) begin
      out_result_kind <= kind_r;
      out_nearest_centre <= kind_r ? ci_r : best_r;
      out_min_distance <= kind_r ? '0 : best_d_r;
      out_bin_count <= kind_r ? h_rd : h_wd;
    end
  end
  assign out_valid = st_r == S_OUT;
endmodule

FILE: design/nearest_centroid_histogram.sv
// Throughput: one multiply-accumulate per cycle; the next request waits for the result.
// Loads and non-final descriptor elements are taken one per cycle while no request is busy or queued.
// Reset (rst_n, synchronous): registers to 1024/128, then a full histogram
// clear pass with input held off; a clear request runs the same pass.
`include "assert_macros.svh"
module nearest_centroid_histogram import nch_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic [CI_W-1:0]          in_centre_index,
  input  logic [EI_W-1:0]          in_element_index,
  input  logic signed [ELEM_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic [CI_W-1:0]          out_nearest_centre,
  output logic [DIST_W-1:0]        out_min_distance,
  output logic [COUNT_W-1:0]       out_bin_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [NC_W-1:0]          cfg_data
);
  logic [NC_W-1:0] ncent_r;
  logic [LEN_W-1:0] len_r;
  logic cb_we, db_we, q_push, q_pop, q_full, q_empty, busy;
  logic [CB_AW-1:0] cb_waddr, cb_raddr;
  logic [ELEM_W-1:0] wdata, cb_rdata, db_rdata;
  logic [EI_W-1:0] db_raddr;
  cmd_t q_cmd, q_dout;
  logic front_ready;

  assign cfg_ready = !busy && q_empty;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncent_r <= NC_W'(MAX_CENTRES);
      len_r <= LEN_W'(MAX_DESC_LEN);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CENTRES) ncent_r <= cfg_data;
      else len_r <= cfg_data[LEN_W-1:0];
    end
  end

  // loads must not overtake a running search
  assign in_ready = front_ready && !busy && q_empty;

  nch_front u_front (
    .in_valid(in_valid && !busy && q_empty), .in_ready(front_ready),
    .in_op(in_op), .in_centre_index(in_centre_index), .in_element_index(in_element_index),
    .in_element_value(in_element_value), .len(len_r), .cb_we(cb_we), .cb_waddr(cb_waddr),
    .wdata(wdata), .db_we(db_we), .q_push(q_push), .q_cmd(q_cmd), .q_full(q_full)
  );
  nch_queue u_q (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_dout)
  );
  nch_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_CENTRES*MAX_DESC_LEN)) u_cb (
    .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(wdata), .raddr(cb_raddr), .rdata(cb_rdata)
  );
  nch_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DESC_LEN)) u_db (
    .clk(clk), .we(db_we), .waddr(cb_waddr[EI_W-1:0]), .wdata(wdata),
    .raddr(db_raddr), .rdata(db_rdata)
  );
  nch_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_cmd(q_dout), .q_pop(q_pop),
    .ncent(ncent_r), .len(len_r), .cb_raddr(cb_raddr), .cb_rdata(cb_rdata),
    .db_raddr(db_raddr), .db_rdata(db_rdata), .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_nearest_centre(out_nearest_centre),
    .out_min_distance(out_min_distance), .out_bin_count(out_bin_count), .busy(busy)
  );

  `ASSERT_CLK(a_no_push_full, !(q_push && q_full), "push into full queue")
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_bin_count), "result lost")
endmodule
